// ===== rtl/dba_pkg.sv =====
// ----------------------------------------------------------------------------
// dba_pkg: shared types and constants
// Digit widths, store depths, operation codes and sequencer states for the
// decimal add, subtract and multiply core.
// ----------------------------------------------------------------------------
package dba_pkg;

  localparam int MaxDigits = 32;
  localparam int DigitW    = 4;
  localparam int LenW      = $clog2(MaxDigits + 1);
  localparam int AddrW     = $clog2(MaxDigits);
  localparam int PAddrW    = $clog2(2 * MaxDigits);
  localparam int PLenW     = $clog2(2 * MaxDigits + 1);

  typedef logic [DigitW-1:0] digit_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_RD,
    ST_ADDSUB,
    ST_SUBCHK,
    ST_MRD,
    ST_MACC,
    ST_MCARRY,
    ST_ORD,
    ST_OUT
  } state_t;

  localparam int Radix = 10;

endpackage

// ===== rtl/dba_ram.sv =====
// ----------------------------------------------------------------------------
// dba_ram: generic single-port-write, single-port-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dba_ram #(
  parameter int Width = 4,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/decimal_bignum_alu_core.sv =====
// ----------------------------------------------------------------------------
// decimal_bignum_alu_core: decimal schoolbook add, subtract and multiply
// Loads digit pairs, then runs one shared digit unit over the stored
// operands under a small sequencer and streams result digits out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake         payload
//  in        input      in_valid/in_stall digit_a digit_b a_present b_present last_digit
//  out       output     out_valid/out_stall result_digit underflow last_result
//  config    input      APB write/read    operation at address 0
//
//  A non-final item is accepted whenever it is offered. The final item starts a
//  job, and multiply first clears the accumulator; the job's length is set by
//  the single digit unit and the one-read-port stores. Result digits then
//  leave one by one, each read from the store and then shown until taken.
//  Reset is synchronous and clears control state; in_stall is high for the
//  whole job and while out_stall holds.
module decimal_bignum_alu_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           digit_a,
  input  logic [3:0]           digit_b,
  input  logic                 a_present,
  input  logic                 b_present,
  input  logic                 last_digit,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           result_digit,
  output logic                 underflow,
  output logic                 last_result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import dba_pkg::*;

  state_t state, state_next;
  op_t    operation, op;
  logic [LenW-1:0]   length_a, length_b, la, lb;
  logic [LenW-1:0]   i, j;
  logic [PLenW-1:0]  k, n;
  logic [3:0]        carry;
  logic              borrow;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = {30'd0, operation};
  always_ff @(posedge clk) begin
    if (rst) begin
      operation <= OP_ADD;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      operation <= op_t'(pwdata[1:0]);
    end
  end

  logic in_acc;
  assign in_stall = (state != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;

  function automatic digit_t sat(input logic [3:0] v);
    sat = (v > 4'd9) ? 4'd9 : v;
  endfunction

  // Operand and product stores.
  logic            a_we, b_we, p_we;
  logic [AddrW-1:0] a_wa, b_wa, a_ra, b_ra;
  digit_t          a_wd, b_wd, a_rd, b_rd, p_wd, p_rd;
  logic [PAddrW-1:0] p_wa, p_ra;

  dba_ram #(.Width(DigitW), .Depth(MaxDigits)) u_a (
    .clk, .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
  dba_ram #(.Width(DigitW), .Depth(MaxDigits)) u_b (
    .clk, .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
  dba_ram #(.Width(DigitW), .Depth(2*MaxDigits)) u_p (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

  logic a_ld, b_ld, empty_a, empty_b;
  assign a_ld = in_acc && a_present && (length_a < LenW'(MaxDigits));
  assign b_ld = in_acc && b_present && (length_b < LenW'(MaxDigits));
  assign empty_a = in_acc && last_digit && !a_ld && length_a == '0;
  assign empty_b = in_acc && last_digit && !b_ld && length_b == '0;

  assign a_we = a_ld || empty_a;
  assign b_we = b_ld || empty_b;
  assign a_wa = a_ld ? length_a[AddrW-1:0] : '0;
  assign b_wa = b_ld ? length_b[AddrW-1:0] : '0;
  assign a_wd = a_ld ? sat(digit_a) : '0;
  assign b_wd = b_ld ? sat(digit_b) : '0;

  // Shared digit unit: acc + a*b + carry (or a + b + carry), then split by ten; a - b - borrow alongside.
  logic [6:0] prod, t;
  logic [3:0] t_hi;
  logic [3:0] dig_lo;
  digit_t     av, bv;
  logic [4:0] sub_s;
  logic       sub_neg;
  assign av = (i < la) ? a_rd : '0;
  assign bv = (i < lb) ? b_rd : '0;
  assign prod = 7'(a_rd * b_rd);
  always_comb begin
    if (op == OP_MUL) begin
      t = prod + 7'(p_rd) + 7'(carry);
    end else begin
      t = 7'(av) + 7'(bv) + 7'(carry);
    end
    // Reciprocal multiply by 205/2048 is exact for t up to 99.
    t_hi   = 4'((15'(t) * 15'd205) >> 11);
    dig_lo = 4'(t - 7'(t_hi) * 7'(Radix));
    sub_s  = 5'(a_rd) - 5'(bv) - 5'(borrow);
    sub_neg = sub_s[4];
  end

  // Read addresses.
  assign a_ra = i[AddrW-1:0];
  assign b_ra = (op == OP_MUL) ? j[AddrW-1:0] : i[AddrW-1:0];
  assign p_ra = (state == ST_ORD || state == ST_OUT) ? k[PAddrW-1:0]
                                                    : PAddrW'(i + j);

  // Product store writes.
  always_comb begin
    p_we = 1'b0;
    p_wa = PAddrW'(i + j);
    p_wd = dig_lo;
    case (state)
      ST_CLEAR: begin
        p_we = 1'b1; p_wa = k[PAddrW-1:0]; p_wd = '0;
      end
      ST_ADDSUB: begin
        p_we = 1'b1; p_wa = PAddrW'(i);
        p_wd = (op == OP_SUB) ? (sub_neg ? 4'(sub_s + 5'd10) : sub_s[3:0]) : dig_lo;
      end
      ST_MACC: begin
        p_we = 1'b1;
      end
      ST_MCARRY: begin
        p_we = 1'b1; p_wa = PAddrW'(j + la); p_wd = carry;
      end
      default: p_we = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: if (in_acc && last_digit) begin
        case (op_t'(operation))
          OP_MUL:  state_next = ST_CLEAR;
          OP_NOP:  state_next = ST_LOAD;
          default: state_next = ST_RD;
        endcase
      end
      ST_CLEAR: if (k == PLenW'(2*MaxDigits-1)) state_next = ST_MRD;
      ST_RD:    state_next = (op == OP_SUB && lb > la) ? ST_SUBCHK : ST_ADDSUB;
      ST_ADDSUB: state_next = (LenW'(i + 1) == ((op == OP_SUB || la > lb) ? la : lb))
                              ? ((op == OP_SUB) ? ST_SUBCHK : ST_ORD) : ST_RD;
      ST_SUBCHK: state_next = ST_ORD;
      ST_MRD:   state_next = ST_MACC;
      ST_MACC:  state_next = (LenW'(i + 1) == la) ? ST_MCARRY : ST_MRD;
      ST_MCARRY: state_next = (LenW'(j + 1) == lb) ? ST_ORD : ST_MRD;
      ST_ORD:   state_next = ST_OUT;
      ST_OUT:   if (!out_stall) state_next = (k + 1 == n) ? ST_LOAD : ST_ORD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      length_a <= '0;
      length_b <= '0;
      underflow <= 1'b0;
    end else begin
      state <= state_next;
      if (a_ld) length_a <= length_a + 1'b1;
      if (b_ld) length_b <= length_b + 1'b1;
      case (state)
        ST_LOAD: if (in_acc && last_digit) begin
          la <= a_ld ? LenW'(length_a + 1) : ((length_a == '0) ? LenW'(1) : length_a);
          lb <= b_ld ? LenW'(length_b + 1) : ((length_b == '0) ? LenW'(1) : length_b);
          length_a <= '0; length_b <= '0;
          op <= operation;
          i <= '0; j <= '0; k <= '0; carry <= '0; borrow <= 1'b0;
          underflow <= 1'b0;
        end
        ST_CLEAR: k <= k + 1'b1;
        ST_ADDSUB: begin
          carry <= t_hi; borrow <= sub_neg; i <= i + 1'b1;
          if (op == OP_SUB) n <= PLenW'(la);
          else n <= PLenW'((la > lb) ? la : lb);
        end
        ST_SUBCHK: begin
          k <= '0;
          if (lb > la || borrow) begin
            underflow <= 1'b1; n <= PLenW'(1);
          end
        end
        ST_MACC: begin
          carry <= t_hi; i <= i + 1'b1;
        end
        ST_MCARRY: begin
          carry <= '0; i <= '0; j <= j + 1'b1;
          n <= PLenW'(la + lb - 1);
          if (LenW'(j + 1) == lb) begin
            k <= '0;
            if (carry != '0) n <= PLenW'(la + lb);
          end
        end
        ST_ORD: if (op == OP_ADD && k == '0 && carry != '0) begin
          // Final carry becomes an extra top digit.
          n <= n + 1'b1;
        end
        ST_OUT: if (!out_stall) k <= k + 1'b1;
        default: ;
      endcase
    end
  end

  // Add's final carry is shown past the top digit, from the carry register.
  logic add_top;
  assign add_top = (op == OP_ADD) && (k == n - 1) && (k == PLenW'((la > lb) ? la : lb));

  // Output drive.
  always_comb begin
    out_valid    = (state == ST_OUT);
    last_result  = (k + 1 == n);
    result_digit = underflow ? 4'd0 : (add_top ? carry : p_rd);
  end

endmodule

// ===== dv/tb_decimal_bignum_alu_core.sv =====
// ----------------------------------------------------------------------------
// tb_decimal_bignum_alu_core: self-checking bench for the decimal ALU core
// Drives digit-pair transfers under random idling, programs the operation
// register between phases, and compares each result digit with a digit-level
// add, subtract and multiply predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_decimal_bignum_alu_core;
  import dba_pkg::*;

  localparam int CycleLimit  = 1_000_000;
  localparam int SettleCycles = 2500;
  localparam int HoldCycles  = 400;

  typedef struct {
    logic [3:0] digit;
    logic       uf;
    logic       last;
  } res_t;

  typedef struct {
    op_t        op;
    logic [3:0] a;
    logic [3:0] b;
    logic       ap;
    logic       bp;
    logic       ld;
    logic       typed;
    logic [3:0] t_digit;
    logic       t_uf;
  } row_t;

  logic        clk, rst;
  logic        in_valid, in_stall;
  logic [3:0]  digit_a, digit_b;
  logic        a_present, b_present, last_digit;
  logic        out_valid, out_stall;
  logic [3:0]  result_digit;
  logic        underflow, last_result;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  decimal_bignum_alu_core dut (.*);

  // Predictor state.
  logic [3:0] a_digits [MaxDigits];
  logic [3:0] b_digits [MaxDigits];
  logic [3:0] prod [2*MaxDigits];
  int         a_len, b_len;
  op_t        cur_op;
  res_t       pending_q[$];

  int errors;
  int cycles;
  int send_pct, stall_pct;
  int hold_req, hold_seen, hold_left;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  function automatic logic [3:0] clamp9(logic [3:0] d);
    return (d > 4'd9) ? 4'd9 : d;
  endfunction

  // Digit-level model: loads a position and, on the final one, queues results.
  function automatic void compute_digits(logic [3:0] da, logic [3:0] db,
                                         logic ap, logic bp, logic ld);
    int la, lb, n, carry, s, borrow, t;
    logic [3:0] r [2*MaxDigits];
    if (ap && a_len < MaxDigits) begin a_digits[a_len] = clamp9(da); a_len++; end
    if (bp && b_len < MaxDigits) begin b_digits[b_len] = clamp9(db); b_len++; end
    if (!ld) return;
    if (a_len == 0) begin a_digits[0] = 0; a_len = 1; end
    if (b_len == 0) begin b_digits[0] = 0; b_len = 1; end
    la = a_len;
    lb = b_len;
    a_len = 0;
    b_len = 0;
    n = 0;
    case (cur_op)
      OP_ADD: begin
        n = (la > lb) ? la : lb;
        carry = 0;
        for (int i = 0; i < n; i++) begin
          s = carry + ((i < la) ? a_digits[i] : 0) + ((i < lb) ? b_digits[i] : 0);
          r[i] = s % Radix;
          carry = s / Radix;
        end
        if (carry != 0) begin r[n] = carry; n++; end
      end
      OP_SUB: begin
        borrow = 0;
        if (lb <= la) begin
          for (int i = 0; i < la; i++) begin
            s = borrow + ((i < lb) ? b_digits[i] : 0);
            if (a_digits[i] >= s) begin r[i] = a_digits[i] - s; borrow = 0; end
            else begin r[i] = a_digits[i] + Radix - s; borrow = 1; end
          end
        end
        if (lb > la || borrow != 0) begin
          pending_q.push_back('{digit: 4'd0, uf: 1'b1, last: 1'b1});
          return;
        end
        n = la;
      end
      OP_MUL: begin
        for (int i = 0; i < 2*MaxDigits; i++) prod[i] = 0;
        for (int j = 0; j < lb; j++) begin
          carry = 0;
          for (int i = 0; i < la; i++) begin
            t = prod[i+j] + a_digits[i] * b_digits[j] + carry;
            prod[i+j] = t % Radix;
            carry = t / Radix;
          end
          prod[j+la] = carry;
        end
        n = la + lb - 1;
        if (prod[n] != 0) n++;
        for (int i = 0; i < n; i++) r[i] = prod[i];
      end
      default: n = 0;
    endcase
    for (int i = 0; i < n; i++)
      pending_q.push_back('{digit: r[i], uf: 1'b0, last: (i + 1 == n)});
  endfunction

  // Result checker.
  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        note_error($sformatf("unexpected result digit=%0d uf=%0b last=%0b",
                             result_digit, underflow, last_result));
      end else begin
        e = pending_q.pop_front();
        if (result_digit !== e.digit || underflow !== e.uf || last_result !== e.last)
          note_error($sformatf("exp digit=%0d uf=%0b last=%0b got digit=%0d uf=%0b last=%0b",
                               e.digit, e.uf, e.last, result_digit, underflow,
                               last_result));
      end
    end
  end

  // Receiver: random stall, or a long counted hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // One input transfer, with an optional gap before it.
  task automatic send_digit(logic [3:0] da, logic [3:0] db, logic ap, logic bp,
                            logic ld);
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_pct) @(posedge clk);
    end
    in_valid   <= 1'b1;
    digit_a    <= da;
    digit_b    <= db;
    a_present  <= ap;
    b_present  <= bp;
    last_digit <= ld;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    compute_digits(da, db, ap, bp, ld);
  endtask

  // Let the block drain, then write and read back the operation register.
  task automatic set_operation(op_t op);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 2'd0;
    pwdata <= 32'(op);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cur_op = op;
    penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[1:0] !== op)
      note_error($sformatf("operation readback exp=%0d got=%0d", op, prdata[1:0]));
    psel <= 1'b0; penable <= 1'b0;
  endtask

  function automatic logic [3:0] rand_digit();
    return ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
  endfunction

  // One job of random operands, with occasional empty positions as noise.
  task automatic random_job(int la, int lb);
    int npos;
    logic [3:0] da, db;
    logic fit;
    npos = (la > lb) ? la : lb;
    if (npos == 0) npos = 1;
    fit = (cur_op == OP_SUB) && $urandom_range(1);
    for (int p = 0; p < npos; p++) begin
      if ($urandom_range(9) == 0)
        send_digit(rand_digit(), rand_digit(), 1'b0, 1'b0, 1'b0);
      da = rand_digit();
      db = rand_digit();
      if (fit && db > da) db = 4'($urandom_range(da > 9 ? 9 : da));
      send_digit(da, db, p < la, p < lb, p == npos - 1);
    end
  endtask

  row_t rows [] = '{
    // Both operands empty: reads as 0 + 0.
    '{OP_ADD, 4'd0, 4'd0, 1'b0, 1'b0, 1'b1, 1'b1, 4'd0, 1'b0},
    '{OP_ADD, 4'd15, 4'd15, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0, 1'b0},
    '{OP_ADD, 4'd10, 4'd9, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0, 1'b0},
    '{OP_ADD, 4'd4, 4'd0, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{OP_ADD, 4'd7, 4'd0, 1'b1, 1'b0, 1'b1, 1'b0, 4'd0, 1'b0},
    '{OP_ADD, 4'd0, 4'd0, 1'b0, 1'b1, 1'b1, 1'b1, 4'd0, 1'b0},
    // Subtraction, including results going negative.
    '{OP_SUB, 4'd3, 4'd5, 1'b1, 1'b1, 1'b1, 1'b1, 4'd0, 1'b1},
    '{OP_SUB, 4'd0, 4'd9, 1'b0, 1'b1, 1'b1, 1'b1, 4'd0, 1'b1},
    '{OP_SUB, 4'd5, 4'd0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0, 1'b0},
    '{OP_SUB, 4'd0, 4'd1, 1'b0, 1'b1, 1'b1, 1'b1, 4'd0, 1'b1},
    '{OP_SUB, 4'd0, 4'd0, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0},
    '{OP_SUB, 4'd9, 4'd3, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0, 1'b0},
    '{OP_SUB, 4'd9, 4'd9, 1'b1, 1'b1, 1'b1, 1'b1, 4'd0, 1'b0},
    // Multiply extremes and the empty operand.
    '{OP_MUL, 4'd9, 4'd9, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0, 1'b0},
    '{OP_MUL, 4'd12, 4'd11, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0, 1'b0},
    '{OP_MUL, 4'd8, 4'd0, 1'b1, 1'b0, 1'b1, 1'b1, 4'd0, 1'b0},
    '{OP_MUL, 4'd1, 4'd1, 1'b1, 1'b1, 1'b1, 1'b1, 4'd1, 1'b0},
    // Unused operation: no results at all.
    '{OP_NOP, 4'd7, 4'd7, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0, 1'b0},
    '{OP_NOP, 4'd7, 4'd7, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0, 1'b0}
  };

  op_t phase_ops [] = '{OP_ADD, OP_SUB, OP_MUL, OP_NOP, OP_ADD, OP_MUL, OP_SUB, OP_ADD,
                        OP_MUL};

  // Main sequence.
  initial begin
    int depth;
    errors = 0; cycles = 0; hold_req = 0; hold_seen = 0; hold_left = 0;
    send_pct = 23; stall_pct = 61;
    a_len = 0; b_len = 0; cur_op = OP_ADD;
    rst = 1'b1;
    in_valid = 1'b0; digit_a = '0; digit_b = '0;
    a_present = 1'b0; b_present = 1'b0; last_digit = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; typed rows replace the predicted single result.
    foreach (rows[k]) begin
      if (rows[k].op != cur_op) set_operation(rows[k].op);
      if (rows[k].typed) begin
        // Drain earlier jobs so only this row's result is replaced.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0) @(posedge clk);
        depth = pending_q.size();
        send_digit(rows[k].a, rows[k].b, rows[k].ap, rows[k].bp, rows[k].ld);
        while (pending_q.size() > depth) void'(pending_q.pop_back());
        pending_q.push_back('{digit: rows[k].t_digit, uf: rows[k].t_uf, last: 1'b1});
      end else begin
        send_digit(rows[k].a, rows[k].b, rows[k].ap, rows[k].bp, rows[k].ld);
      end
    end

    // Random phases under changing operation and idling.
    foreach (phase_ops[ph]) begin
      set_operation(phase_ops[ph]);
      if (ph == 3) begin send_pct = 61; stall_pct = 23; end
      if (ph == 6) begin send_pct = 0; stall_pct = 0; end
      for (int j = 0; j < 6; j++) begin
        // Long receiver hold-off while the sender keeps offering.
        if (ph == 5 && j == 1) hold_req++;
        if (j == 0 && (ph == 1 || ph == 2 || ph == 7))
          random_job(MaxDigits + 2, MaxDigits + 1);
        else
          random_job($urandom_range(6), $urandom_range(6));
        if (ph == 4 && j == 4) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_q.size() != 0) @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== decimal_bignum_alu_core.f =====
rtl/dba_pkg.sv
rtl/dba_ram.sv
rtl/decimal_bignum_alu_core.sv
dv/tb_decimal_bignum_alu_core.sv
